// ===== hdl/s5hrp_pkg.sv =====
package s5hrp_pkg;

    typedef enum logic [8:0] {
        PH_GREET_VER  = 9'b000000001,
        PH_GREET_METH = 9'b000000010,
        PH_HDR_VER    = 9'b000000100,
        PH_HDR_REP    = 9'b000001000,
        PH_HDR_RSV    = 9'b000010000,
        PH_HDR_ATYP   = 9'b000100000,
        PH_HDR_ADDR0  = 9'b001000000,
        PH_TAIL       = 9'b010000000,
        PH_DONE       = 9'b100000000
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_GREET = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_REFUSED   = 3'd4;
    localparam logic [2:0] ST_BAD_ATYP  = 3'd5;

    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] METHOD_NOAUTH = 8'h00;
    localparam logic [7:0] ATYP_IPV4     = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
    localparam logic [7:0] ATYP_IPV6     = 8'h04;

    // tail beats still due after the first address byte (address + port - 1)
    localparam logic [8:0] TAIL_IPV4 = 9'd5;
    localparam logic [8:0] TAIL_IPV6 = 9'd17;
    localparam logic [8:0] TAIL_DOMAIN_EXTRA = 9'd2;

endpackage

// ===== hdl/socks5_handshake_reply_parser.sv =====
// Path: the input beat ending the handshake is held in the input register, then the
// result beat is registered in the result register.
// Throughput: one input beat per cycle while the result side is not stalled.
// Set by the input register and the result register around the parser update.
// Reset (aresetn low, synchronous): both stages empty, parser back to the
// greeting version byte with all saved fields cleared.
module socks5_handshake_reply_parser
    import s5hrp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_reply_byte,
    input  logic       s_restart,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_reply_code,
    output logic [7:0] m_address_type
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    phase_t     phase_reg, phase_next;
    logic       header_bad_reg, header_bad_next;
    logic [7:0] saved_reply_reg, saved_reply_next;
    logic [7:0] saved_addr_type_reg, saved_addr_type_next;
    logic [8:0] bytes_left_reg, bytes_left_next;

    logic       m_valid_reg;
    logic [2:0] m_status_reg, m_status_next;
    logic [7:0] m_reply_code_reg, m_reply_code_next;
    logic [7:0] m_address_type_reg, m_address_type_next;

    logic       emit;
    logic       out_free;
    logic       fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg    <= s_reply_byte;
            in_restart_reg <= s_restart;
        end
    end

    always_comb begin
        phase_next           = phase_reg;
        header_bad_next      = header_bad_reg;
        saved_reply_next     = saved_reply_reg;
        saved_addr_type_next = saved_addr_type_reg;
        bytes_left_next      = bytes_left_reg;
        emit                 = 1'b0;
        m_status_next        = ST_OK;
        m_reply_code_next    = 8'd0;
        m_address_type_next  = 8'd0;

        if (in_restart_reg) begin
            phase_next           = PH_GREET_VER;
            header_bad_next      = 1'b0;
            saved_reply_next     = 8'd0;
            saved_addr_type_next = 8'd0;
            bytes_left_next      = 9'd0;
        end else begin
            unique case (phase_reg)
                PH_GREET_VER: begin
                    header_bad_next = (in_byte_reg != SOCKS_VER);
                    phase_next      = PH_GREET_METH;
                end
                PH_GREET_METH: begin
                    if (header_bad_reg) begin
                        emit          = 1'b1;
                        m_status_next = ST_BAD_GREET;
                        phase_next    = PH_DONE;
                    end else if (in_byte_reg != METHOD_NOAUTH) begin
                        emit          = 1'b1;
                        m_status_next = ST_REJECTED;
                        phase_next    = PH_DONE;
                    end else begin
                        header_bad_next = 1'b0;
                        phase_next      = PH_HDR_VER;
                    end
                end
                PH_HDR_VER: begin
                    header_bad_next = (in_byte_reg != SOCKS_VER);
                    phase_next      = PH_HDR_REP;
                end
                PH_HDR_REP: begin
                    saved_reply_next = in_byte_reg;
                    phase_next       = PH_HDR_RSV;
                end
                PH_HDR_RSV: begin
                    if (in_byte_reg != 8'd0) begin
                        header_bad_next = 1'b1;
                    end
                    phase_next = PH_HDR_ATYP;
                end
                PH_HDR_ATYP: begin
                    saved_addr_type_next = in_byte_reg;
                    phase_next           = PH_HDR_ADDR0;
                end
                PH_HDR_ADDR0: begin
                    m_address_type_next = saved_addr_type_reg;
                    if (header_bad_reg) begin
                        emit          = 1'b1;
                        m_status_next = ST_BAD_HDR;
                        phase_next    = PH_DONE;
                    end else if (saved_reply_reg != 8'd0) begin
                        emit              = 1'b1;
                        m_status_next     = ST_REFUSED;
                        m_reply_code_next = saved_reply_reg;
                        phase_next        = PH_DONE;
                    end else if (saved_addr_type_reg == ATYP_IPV4) begin
                        bytes_left_next = TAIL_IPV4;
                        phase_next      = PH_TAIL;
                    end else if (saved_addr_type_reg == ATYP_IPV6) begin
                        bytes_left_next = TAIL_IPV6;
                        phase_next      = PH_TAIL;
                    end else if (saved_addr_type_reg == ATYP_DOMAIN) begin
                        // domain length byte L: L name bytes + 2 port bytes remain
                        bytes_left_next = {1'b0, in_byte_reg} + TAIL_DOMAIN_EXTRA;
                        phase_next      = PH_TAIL;
                    end else begin
                        emit          = 1'b1;
                        m_status_next = ST_BAD_ATYP;
                        phase_next    = PH_DONE;
                    end
                end
                PH_TAIL: begin
                    bytes_left_next     = bytes_left_reg - 9'd1;
                    m_address_type_next = saved_addr_type_reg;
                    if (bytes_left_reg == 9'd1) begin
                        emit          = 1'b1;
                        m_status_next = ST_OK;
                        phase_next    = PH_DONE;
                    end
                end
                default: begin
                    // done: bytes are dropped until restart
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_GREET_VER;
            header_bad_reg      <= 1'b0;
            saved_reply_reg     <= 8'd0;
            saved_addr_type_reg <= 8'd0;
            bytes_left_reg      <= 9'd0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg           <= phase_next;
                header_bad_reg      <= header_bad_next;
                saved_reply_reg     <= saved_reply_next;
                saved_addr_type_reg <= saved_addr_type_next;
                bytes_left_reg      <= bytes_left_next;
            end
            if (out_free) begin
                m_valid_reg <= fire && emit;
            end
        end
        if (fire && emit) begin
            m_status_reg       <= m_status_next;
            m_reply_code_reg   <= m_reply_code_next;
            m_address_type_reg <= m_address_type_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_reply_code   = m_reply_code_reg;
    assign m_address_type = m_address_type_reg;

    a_result_from_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a parsed beat");

    a_refused_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_REFUSED) |-> (m_reply_code_reg != 8'd0))
        else $error("refused result carries zero reply code");

    a_code_only_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != ST_REFUSED) |-> (m_reply_code_reg == 8'd0))
        else $error("reply code set on non-refused result");

    a_greet_no_atyp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ((m_status_reg == ST_BAD_GREET) || (m_status_reg == ST_REJECTED))
        |-> (m_address_type_reg == 8'd0))
        else $error("address type set on greeting result");

    a_tail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_TAIL) |-> (bytes_left_reg != 9'd0))
        else $error("tail phase with no bytes left");

endmodule
